// ===== rtl/tookpt_pkg.sv =====
// Package for the tristate OOK pulse transmitter.
// Holds the microcode word, opcodes, jump conditions, addresses and pulse tables.
// No dependencies; used by every module of the block.
package tookpt_pkg;

    // Microcode program counter and step addresses
    typedef logic [2:0] t_upc;

    localparam t_upc UA_FETCH = 3'd0;
    localparam t_upc UA_TICK  = 3'd1;
    localparam t_upc UA_UNIT  = 3'd2;
    localparam t_upc UA_PHASE = 3'd3;
    localparam t_upc UA_DIGIT = 3'd4;
    localparam t_upc UA_LOAD  = 3'd5;
    localparam t_upc UA_DIV   = 3'd6;
    localparam t_upc UA_EMIT  = 3'd7;

    // Datapath operations
    typedef enum logic [2:0] {
        OP_FETCH,
        OP_TICK,
        OP_UNIT,
        OP_PHASE,
        OP_DIGIT,
        OP_LOAD,
        OP_DIV,
        OP_EMIT
    } t_uop;

    // Next-address selection
    typedef enum logic [2:0] {
        UC_NEXT,      // pc + 1
        UC_JUMP,      // target
        UC_DISPATCH,  // wait for an input beat, then branch on its kind
        UC_ROLL,      // pc + 1 on counter rollover, else target
        UC_LOOP,      // target until the digit loop is done, then pc + 1
        UC_WAIT_OUT   // hold until the output register is free, then target
    } t_ucond;

    typedef struct packed {
        t_uop   op;
        t_ucond cond;
        t_upc   target;
    } t_uword;

    // Status from datapath to sequencer
    typedef struct packed {
        logic roll;
        logic active;
        logic out_free;
    } t_flags;

    // Request kinds
    localparam logic REQ_TICK  = 1'b0;
    localparam logic REQ_START = 1'b1;

    // Configuration register indexes
    localparam logic CFG_PERIOD_LEN   = 1'b0;
    localparam logic CFG_REPEATS_LOG2 = 1'b1;

    localparam logic [8:0] PERIOD_LEN_RST   = 9'd375;
    localparam logic [2:0] REPEATS_LOG2_RST = 3'd3;

    // Code width and divide-by-three reciprocal: floor(c * RECIP / 2^21) == c / 3
    localparam int unsigned CODE_W    = 20;
    localparam logic [19:0] DIV3_RECIP = 20'd699051;
    localparam int unsigned DIV3_SHIFT = 21;

    // Pulse lengths in period units: [digit][phase]
    localparam logic [4:0] SEG_UNITS [4][4] = '{
        '{5'd1, 5'd3, 5'd1, 5'd3},
        '{5'd3, 5'd1, 5'd3, 5'd1},
        '{5'd1, 5'd3, 5'd3, 5'd1},
        '{5'd1, 5'd3, 5'd3, 5'd1}
    };
    localparam logic [4:0] SYNC_HIGH_UNITS = 5'd1;
    localparam logic [4:0] SYNC_LOW_UNITS  = 5'd31;

endpackage

// ===== rtl/tookpt_ucode_rom.sv =====
// Microcode program of the transmitter: one control word per step.
// Depends on tookpt_pkg for the word layout, opcodes and addresses.
module tookpt_ucode_rom (
    input  tookpt_pkg::t_upc   i_pc,
    output tookpt_pkg::t_uword o_word
);

    // Decode program address into control word
    always_comb begin
        unique case (i_pc)
            tookpt_pkg::UA_FETCH: o_word = '{tookpt_pkg::OP_FETCH, tookpt_pkg::UC_DISPATCH,
                                             tookpt_pkg::UA_FETCH};
            tookpt_pkg::UA_TICK:  o_word = '{tookpt_pkg::OP_TICK,  tookpt_pkg::UC_ROLL,
                                             tookpt_pkg::UA_EMIT};
            tookpt_pkg::UA_UNIT:  o_word = '{tookpt_pkg::OP_UNIT,  tookpt_pkg::UC_ROLL,
                                             tookpt_pkg::UA_EMIT};
            tookpt_pkg::UA_PHASE: o_word = '{tookpt_pkg::OP_PHASE, tookpt_pkg::UC_ROLL,
                                             tookpt_pkg::UA_EMIT};
            tookpt_pkg::UA_DIGIT: o_word = '{tookpt_pkg::OP_DIGIT, tookpt_pkg::UC_JUMP,
                                             tookpt_pkg::UA_EMIT};
            tookpt_pkg::UA_LOAD:  o_word = '{tookpt_pkg::OP_LOAD,  tookpt_pkg::UC_NEXT,
                                             tookpt_pkg::UA_FETCH};
            tookpt_pkg::UA_DIV:   o_word = '{tookpt_pkg::OP_DIV,   tookpt_pkg::UC_LOOP,
                                             tookpt_pkg::UA_DIV};
            tookpt_pkg::UA_EMIT:  o_word = '{tookpt_pkg::OP_EMIT,  tookpt_pkg::UC_WAIT_OUT,
                                             tookpt_pkg::UA_FETCH};
            default:              o_word = '{tookpt_pkg::OP_FETCH, tookpt_pkg::UC_DISPATCH,
                                             tookpt_pkg::UA_FETCH};
        endcase
    end

endmodule

// ===== rtl/tookpt_sequencer.sv =====
// Microcode sequencer: program counter, digit loop counter and jump logic.
// Depends on tookpt_pkg and tookpt_ucode_rom.
module tookpt_sequencer #(
    parameter int DIGITS = 12
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_req_type,
    input  tookpt_pkg::t_flags  i_flags,
    output tookpt_pkg::t_uword  o_word,
    output logic                o_fetch
);

    localparam int LC_W = $clog2(DIGITS + 1);

    tookpt_pkg::t_upc r_pc, n_pc;
    logic [LC_W-1:0]  r_loop, n_loop;
    logic             w_loop_done;

    tookpt_ucode_rom u_rom (
        .i_pc   (r_pc),
        .o_word (o_word)
    );

    assign o_fetch     = (o_word.op == tookpt_pkg::OP_FETCH);
    assign w_loop_done = (r_loop == LC_W'(DIGITS - 1));

    // Select next step
    always_comb begin
        n_pc   = r_pc;
        n_loop = r_loop;
        case (o_word.cond)
            tookpt_pkg::UC_NEXT: n_pc = r_pc + 3'd1;
            tookpt_pkg::UC_JUMP: n_pc = o_word.target;
            tookpt_pkg::UC_DISPATCH: begin
                if (i_in_valid) begin
                    if (i_req_type == tookpt_pkg::REQ_TICK && i_flags.active) begin
                        n_pc = tookpt_pkg::UA_TICK;
                    end else if (i_req_type == tookpt_pkg::REQ_START && !i_flags.active) begin
                        n_pc = tookpt_pkg::UA_LOAD;
                    end else begin
                        n_pc = tookpt_pkg::UA_EMIT;
                    end
                end
            end
            tookpt_pkg::UC_ROLL: n_pc = i_flags.roll ? r_pc + 3'd1 : o_word.target;
            tookpt_pkg::UC_LOOP: begin
                if (w_loop_done) begin
                    n_pc   = r_pc + 3'd1;
                    n_loop = '0;
                end else begin
                    n_pc   = o_word.target;
                    n_loop = r_loop + LC_W'(1);
                end
            end
            tookpt_pkg::UC_WAIT_OUT: begin
                if (i_flags.out_free) n_pc = o_word.target;
            end
            default: n_pc = tookpt_pkg::UA_FETCH;
        endcase
    end

    // Hold program counter and loop counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc   <= tookpt_pkg::UA_FETCH;
            r_loop <= '0;
        end else begin
            r_pc   <= n_pc;
            r_loop <= n_loop;
        end
    end

endmodule

// ===== rtl/tookpt_datapath.sv =====
// Datapath: config registers, digit buffer and divider, pulse counters, result registers.
// Depends on tookpt_pkg; driven by the control word from tookpt_sequencer.
module tookpt_datapath #(
    parameter int DIGITS = 12
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  tookpt_pkg::t_uword               i_word,
    input  logic                             i_accept,
    input  logic                             i_req_type,
    input  logic [tookpt_pkg::CODE_W-1:0]    i_code,
    input  logic                             i_cfg_write,
    input  logic                             i_cfg_index,
    input  logic [8:0]                       i_cfg_data,
    input  logic                             i_out_stall,
    output tookpt_pkg::t_flags               o_flags,
    output logic                             o_out_valid,
    output logic                             o_pin_level,
    output logic                             o_busy_res,
    output logic                             o_done_res
);

    localparam int DI_W  = $clog2(DIGITS + 1);
    localparam int BUF_W = 2 * DIGITS;
    localparam int CW    = tookpt_pkg::CODE_W;

    logic [8:0]       r_period_len;
    logic [2:0]       r_repeats_log2;
    logic [BUF_W-1:0] r_buf;
    logic [CW-1:0]    r_work;
    logic [DI_W-1:0]  r_di;
    logic [1:0]       r_phase;
    logic [4:0]       r_unit;
    logic [8:0]       r_tick;
    logic [7:0]       r_repeat;
    logic             r_active;
    logic             r_res_lvl, r_res_busy, r_res_done;
    logic             r_out_valid, r_out_lvl, r_out_busy, r_out_done;

    logic [2*CW-1:0]  w_prod;
    logic [CW-1:0]    w_quot;
    logic [CW:0]      w_quot3;
    logic [1:0]       w_rem;
    logic [8:0]       w_plen;
    logic [8:0]       w_tick_inc;
    logic [4:0]       w_unit_inc;
    logic [1:0]       w_phase_inc;
    logic [7:0]       w_repeat_inc;
    logic [8:0]       w_repeat_lim;
    logic             w_in_sync;
    logic [1:0]       w_digit;
    logic [4:0]       w_seg;
    logic             w_cur_lvl;
    logic             w_out_free;
    logic             w_roll;

    // Divide working code by three, remainder is the next digit
    assign w_prod  = r_work * tookpt_pkg::DIV3_RECIP;
    assign w_quot  = CW'(w_prod >> tookpt_pkg::DIV3_SHIFT);
    assign w_quot3 = {w_quot, 1'b0} + {1'b0, w_quot};
    assign w_rem   = r_work[1:0] - w_quot3[1:0];

    // Current pulse segment length in period units
    assign w_in_sync = (r_di >= DI_W'(DIGITS));
    assign w_digit   = 2'(r_buf >> {r_di, 1'b0});
    always_comb begin
        if (w_in_sync) begin
            w_seg = r_phase[0] ? tookpt_pkg::SYNC_LOW_UNITS : tookpt_pkg::SYNC_HIGH_UNITS;
        end else begin
            w_seg = tookpt_pkg::SEG_UNITS[w_digit][r_phase];
        end
    end

    assign w_plen       = (r_period_len == 9'd0) ? 9'd1 : r_period_len;
    assign w_tick_inc   = r_tick + 9'd1;
    assign w_unit_inc   = r_unit + 5'd1;
    assign w_phase_inc  = r_phase + 2'd1;
    assign w_repeat_inc = r_repeat + 8'd1;
    assign w_repeat_lim = 9'd1 << r_repeats_log2;
    assign w_cur_lvl    = r_active && !r_phase[0];
    assign w_out_free   = !r_out_valid || !i_out_stall;

    // Rollover flag for the counter the current step advances
    always_comb begin
        case (i_word.op)
            tookpt_pkg::OP_TICK:  w_roll = (w_tick_inc >= w_plen);
            tookpt_pkg::OP_UNIT:  w_roll = (w_unit_inc >= w_seg);
            tookpt_pkg::OP_PHASE: w_roll = (w_phase_inc == 2'd0) ||
                                           (w_in_sync && w_phase_inc >= 2'd2);
            default:              w_roll = 1'b0;
        endcase
    end
    assign o_flags = '{roll: w_roll, active: r_active, out_free: w_out_free};

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period_len   <= tookpt_pkg::PERIOD_LEN_RST;
            r_repeats_log2 <= tookpt_pkg::REPEATS_LOG2_RST;
        end else if (i_cfg_write) begin
            unique case (i_cfg_index)
                tookpt_pkg::CFG_PERIOD_LEN:   r_period_len   <= i_cfg_data;
                tookpt_pkg::CFG_REPEATS_LOG2: r_repeats_log2 <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // Execute the control word on transmitter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf    <= '0;
            r_di     <= '0;
            r_phase  <= '0;
            r_unit   <= '0;
            r_tick   <= '0;
            r_repeat <= '0;
            r_active <= 1'b0;
        end else begin
            case (i_word.op)
                tookpt_pkg::OP_LOAD: begin
                    r_di     <= '0;
                    r_phase  <= '0;
                    r_unit   <= '0;
                    r_tick   <= '0;
                    r_repeat <= '0;
                    r_active <= 1'b1;
                end
                tookpt_pkg::OP_DIV: begin
                    // Low digit first in, so it ends up sent last
                    r_buf <= {r_buf[BUF_W-3:0], w_rem};
                end
                tookpt_pkg::OP_TICK: begin
                    r_tick <= w_roll ? 9'd0 : w_tick_inc;
                end
                tookpt_pkg::OP_UNIT: begin
                    r_unit <= w_roll ? 5'd0 : w_unit_inc;
                end
                tookpt_pkg::OP_PHASE: begin
                    r_phase <= w_roll ? 2'd0 : w_phase_inc;
                end
                tookpt_pkg::OP_DIGIT: begin
                    if (!w_in_sync) begin
                        r_di <= r_di + DI_W'(1);
                    end else begin
                        r_di <= '0;
                        if ({1'b0, w_repeat_inc} >= w_repeat_lim) begin
                            r_repeat <= '0;
                            r_active <= 1'b0;
                        end else begin
                            r_repeat <= w_repeat_inc;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Capture the input beat and the result fields that follow from it
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_work     <= i_code;
            r_res_lvl  <= (i_req_type == tookpt_pkg::REQ_START && !r_active) ? 1'b1 : w_cur_lvl;
            r_res_busy <= (i_req_type == tookpt_pkg::REQ_START) || r_active;
            r_res_done <= 1'b0;
        end else if (i_word.op == tookpt_pkg::OP_DIV) begin
            r_work <= w_quot;
        end else if (i_word.op == tookpt_pkg::OP_DIGIT) begin
            r_res_done <= w_in_sync && ({1'b0, w_repeat_inc} >= w_repeat_lim);
        end
    end

    // Hand the result to the output register; drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_word.op == tookpt_pkg::OP_EMIT && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_word.op == tookpt_pkg::OP_EMIT && w_out_free) begin
            r_out_lvl  <= r_res_lvl;
            r_out_busy <= r_res_busy;
            r_out_done <= r_res_done;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_pin_level = r_out_lvl;
    assign o_busy_res  = r_out_busy;
    assign o_done_res  = r_out_done;

endmodule

// ===== rtl/tristate_ook_pulse_transmitter_core.sv =====
// Top level of the tristate OOK pulse transmitter.
// Depends on tookpt_pkg, tookpt_sequencer and tookpt_datapath.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall): each beat is a tick (one microsecond of
//   pin time) or a start carrying a 20-bit code. Every beat gives exactly one result
//   beat on the output channel (o_out_valid / i_out_stall): the pin level, busy and
//   done flags. A start while a telegram is running changes nothing.
//   Configuration channel (i_cfg_valid / o_cfg_ready, always ready): index 0 writes
//   the period length in ticks, index 1 the log2 of the repeat count. Write only while
//   no beat is in flight.
// Sequence, from acceptance to result:
//   a start that loads a code runs one load step, then one digit per cycle from the
//   divide-by-three unit; a tick while busy runs as far along the tick/unit/phase/digit
//   chain as it rolls over; an ignored start or an idle tick goes straight to the
//   result step. One item is in work at a time: the next beat is taken at the fetch
//   step that follows the result step.
// Reset: synchronous, active low; the block comes up idle with period 375, repeats 2^3.
// Stall: a stalled result holds in the output register; the program waits at its
//   result step and takes no new beat until that register frees up.
module tristate_ook_pulse_transmitter_core #(
    parameter int DIGITS = 12
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_req_type,
    input  logic [19:0] i_code,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_pin_level,
    output logic        o_busy_res,
    output logic        o_done_res,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [8:0]  i_cfg_data
);

    tookpt_pkg::t_uword w_word;
    tookpt_pkg::t_flags w_flags;
    logic               w_fetch;
    logic               w_accept;

    // Take an input beat only at the fetch step
    assign o_in_stall  = !w_fetch;
    assign w_accept    = i_in_valid && w_fetch;
    assign o_cfg_ready = 1'b1;

    tookpt_sequencer #(
        .DIGITS (DIGITS)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_req_type (i_req_type),
        .i_flags    (w_flags),
        .o_word     (w_word),
        .o_fetch    (w_fetch)
    );

    tookpt_datapath #(
        .DIGITS (DIGITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_word      (w_word),
        .i_accept    (w_accept),
        .i_req_type  (i_req_type),
        .i_code      (i_code),
        .i_cfg_write (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_stall (i_out_stall),
        .o_flags     (w_flags),
        .o_out_valid (o_out_valid),
        .o_pin_level (o_pin_level),
        .o_busy_res  (o_busy_res),
        .o_done_res  (o_done_res)
    );

endmodule
